@@ hw/rtl/atan2or_pkg.sv @@
// Shared types and constants for the octant atan2 pipeline.
`timescale 1ns / 1ps

package atan2or_pkg;

  // Q16 ratio quotient width, range 0..65536
  localparam int QW = 17;
  localparam int ANGLE_W = 17;

  localparam logic [11:0] INNER_BASE = 12'd2552;
  localparam logic [26:0] INNER_COEF = 27'd691;
  localparam logic signed [17:0] RATIO_ONE = 18'sd65536;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd16384;
  localparam logic signed [17:0] HALF_TURN = 18'sd32768;

  typedef struct packed {
    logic zero;
    logic swap;
    logic xneg;
    logic yneg;
  } flags_t;

endpackage

@@ hw/rtl/atan2or_div_step.sv @@
// One registered restoring-division step producing one quotient bit.
`timescale 1ns / 1ps

module atan2or_div_step import atan2or_pkg::*; #(
  parameter int MW = 33,
  parameter bit FIRST = 1'b0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [MW-1:0] rem_in,
  input  logic [MW-1:0] hi_in,
  input  logic [QW-1:0] q_in,
  input  flags_t        flags_in,
  output logic          valid_out,
  output logic [MW-1:0] rem_out,
  output logic [MW-1:0] hi_out,
  output logic [QW-1:0] q_out,
  output flags_t        flags_out
);

  logic [MW:0] rem_sh;
  logic [MW:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = FIRST ? {1'b0, rem_in} : {rem_in, 1'b0};
    diff   = rem_sh - {1'b0, hi_in};
    ge     = rem_sh >= {1'b0, hi_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      rem_out   <= ge ? diff[MW-1:0] : rem_sh[MW-1:0];
      hi_out    <= hi_in;
      q_out     <= {q_in[QW-2:0], ge};
      flags_out <= flags_in;
    end
  end

endmodule

@@ hw/rtl/atan2_octant_rational_approx.sv @@
// Top level: pipelined atan2 by octant reduction and rational approximation.
`timescale 1ns / 1ps

// Angle of a signed vector (coord_y, coord_x) in brads, 65536 to a full turn,
// emitted as 17-bit two's complement in -32768..32768; (0,0) gives 0. Only the
// low COORD_WIDTH bits of each coordinate are used. One transaction is taken
// per clock while the output is not stalled; the pipe is one magnitude/octant
// stage, 17 restoring division steps (one quotient bit each) for the Q16
// ratio, then three stages for polynomial and reflection. The whole pipeline
// holds while a result waits under stall: in_stall = out_stall if out_valid is high.
module atan2_octant_rational_approx import atan2or_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [31:0]        coord_y,
  input  logic signed [31:0]        coord_x,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [ANGLE_W-1:0] angle
);

  localparam int W  = COORD_WIDTH;
  localparam int MW = COORD_WIDTH + 1;

  logic en;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  // front stage: magnitudes and octant
  logic [W-1:0]  y_raw, x_raw;
  logic [MW-1:0] ay, ax;
  flags_t        f0_next;

  always_comb begin
    y_raw = coord_y[W-1:0];
    x_raw = coord_x[W-1:0];
    ay = y_raw[W-1] ? (~{1'b1, y_raw} + 1'b1) : {1'b0, y_raw};
    ax = x_raw[W-1] ? (~{1'b1, x_raw} + 1'b1) : {1'b0, x_raw};
    f0_next.zero = (ay == '0) && (ax == '0);
    f0_next.swap = ay > ax;
    f0_next.xneg = x_raw[W-1];
    f0_next.yneg = y_raw[W-1];
  end

  logic          v_a   [0:QW];
  logic [MW-1:0] rem_a [0:QW];
  logic [MW-1:0] hi_a  [0:QW];
  logic [QW-1:0] q_a   [0:QW];
  flags_t        f_a   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a[0] <= 1'b0;
    end else if (en) begin
      v_a[0] <= in_valid;
    end
    if (en) begin
      rem_a[0] <= f0_next.swap ? ax : ay;
      hi_a[0]  <= f0_next.swap ? ay : ax;
      q_a[0]   <= '0;
      f_a[0]   <= f0_next;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    atan2or_div_step #(
      .MW    (MW),
      .FIRST (i == 0)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (v_a[i]),
      .rem_in    (rem_a[i]),
      .hi_in     (hi_a[i]),
      .q_in      (q_a[i]),
      .flags_in  (f_a[i]),
      .valid_out (v_a[i+1]),
      .rem_out   (rem_a[i+1]),
      .hi_out    (hi_a[i+1]),
      .q_out     (q_a[i+1]),
      .flags_out (f_a[i+1])
    );
  end

  // P1: products of the ratio
  logic [QW-1:0]     r;
  logic signed [17:0] rs, rm;
  logic [26:0]        m1_next;
  logic signed [35:0] t_next;

  always_comb begin
    r  = q_a[QW];
    rs = $signed({1'b0, r});
    rm = rs - RATIO_ONE;
    m1_next = {10'b0, r} * INNER_COEF;
    t_next  = rs * rm;
  end

  logic               v1;
  logic [26:0]        m1;
  logic signed [35:0] t1_prod;
  logic [13:0]        r1;
  flags_t             f1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v_a[QW];
    end
    if (en) begin
      m1      <= m1_next;
      t1_prod <= t_next;
      r1      <= r[16:3];
      f1      <= f_a[QW];
    end
  end

  // P2: bend product
  logic [11:0]        inner;
  logic signed [15:0] tq;
  logic signed [28:0] p_next;

  always_comb begin
    inner  = INNER_BASE + {1'b0, m1[26:16]};
    tq     = t1_prod[31:16];
    p_next = tq * $signed({1'b0, inner});
  end

  logic               v2;
  logic signed [28:0] p2;
  logic [13:0]        r2;
  flags_t             f2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      p2 <= p_next;
      r2 <= r1;
      f2 <= f1;
    end
  end

  // P3: octant result and reflections
  logic signed [17:0] a0, a1, a2, a3;

  always_comb begin
    // bend is never positive, so the shifted product needs sign extension
    a0 = $signed({4'b0, r2}) - 18'($signed(p2[28:16]));
    a1 = f2.swap ? (QUARTER_TURN - a0) : a0;
    a2 = f2.xneg ? (HALF_TURN - a1) : a1;
    a3 = f2.yneg ? -a2 : a2;
    if (f2.zero) begin
      a3 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      angle <= a3[ANGLE_W-1:0];
    end
  end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the octant atan2 pipeline.
`timescale 1ns / 1ps

module tb;
  import atan2or_pkg::*;

  localparam int CW = 32;
  localparam int LATENCY = 21;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 650;
  localparam int N_DIRECTED = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] coord_y = '0;
  logic signed [31:0] coord_x = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ANGLE_W-1:0] angle;

  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_e;

  phase_e phase = PH_FREE;
  bit hold_sink = 1'b0;
  logic [ANGLE_W-1:0] angle_q[$];
  int errors = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  atan2_octant_rational_approx #(.COORD_WIDTH(CW)) u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .coord_y(coord_y), .coord_x(coord_x), .out_valid(out_valid),
    .out_stall(out_stall), .angle(angle)
  );

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [ANGLE_W-1:0] predict_angle(logic [31:0] yin,
                                                       logic [31:0] xin);
    longint y, x, ax, ay, lo, hi, r, inner, bend, a;
    y = longint'($signed(yin[CW-1:0]));
    x = longint'($signed(xin[CW-1:0]));
    if (x == 0 && y == 0) return '0;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    lo = (ay <= ax) ? ay : ax;
    hi = (ay <= ax) ? ax : ay;
    r = (lo * 65536) / hi;
    inner = 2552 + floor_sh(691 * r, 16);
    bend = floor_sh(floor_sh(r * (r - 65536), 16) * inner, 16);
    a = floor_sh(r * 8192, 16) - bend;
    if (ay > ax) a = 16384 - a;
    if (x < 0) a = 32768 - a;
    if (y < 0) a = -a;
    return a[ANGLE_W-1:0];
  endfunction

  // directed rows: y, x, typed expectation where obvious
  typedef struct {
    logic [31:0] y;
    logic [31:0] x;
    bit known;
    logic [ANGLE_W-1:0] a;
  } row_t;

  row_t dir_tab[N_DIRECTED] = '{
    '{32'sd0, 32'sd0, 1'b1, 17'd0},
    '{32'sd0, 32'sd1, 1'b1, 17'd0},
    '{32'sd1, 32'sd0, 1'b1, 17'd16384},
    '{32'sd0, -32'sd1, 1'b1, 17'd32768},
    '{-32'sd1, 32'sd0, 1'b1, -17'sd16384},
    '{32'sd0, 32'h8000_0000, 1'b1, 17'd32768},
    '{32'h8000_0000, 32'sd0, 1'b1, -17'sd16384},
    '{32'h7fff_ffff, 32'sd0, 1'b1, 17'd16384},
    '{32'sd0, 32'h7fff_ffff, 1'b1, 17'd0},
    '{32'sd5, 32'sd5, 1'b0, '0},
    '{-32'sd5, 32'sd5, 1'b0, '0},
    '{32'sd5, -32'sd5, 1'b0, '0},
    '{-32'sd5, -32'sd5, 1'b0, '0},
    '{32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
    '{32'h7fff_ffff, 32'h8000_0000, 1'b0, '0},
    '{32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0},
    '{32'sd1, 32'h7fff_ffff, 1'b0, '0},
    '{32'h7fff_fffe, -32'sd3, 1'b0, '0},
    '{32'hffff_ffff, 32'h8000_0000, 1'b0, '0}
  };

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom_range(15) - 8;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // valid stays high across back-to-back transactions; dropped only when idling
  task automatic send(logic [31:0] y, logic [31:0] x, bit known,
                      logic [ANGLE_W-1:0] a);
    while ((phase == PH_SRC_IDLE || phase == PH_BOTH) && roll(phase == PH_BOTH ? 13 : 51)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    coord_y <= y;
    coord_x <= x;
    angle_q.push_back(known ? a : predict_angle(y, x));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_sink) out_stall <= 1'b1;
    else case (phase)
      PH_SNK_STALL: out_stall <= roll(51);
      PH_BOTH: out_stall <= roll(13);
      default: out_stall <= 1'b0;
    endcase
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected angle transaction, got %0d", $time, angle);
        errors++;
      end else begin
        if (angle !== angle_q[0]) begin
          $display("%0t: angle mismatch exp %0d got %0d", $time,
                   $signed(angle_q[0]), angle);
          errors++;
        end
        void'(angle_q.pop_front());
      end
    end
  end

  // watchdog on accepted transactions either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // long sink hold-off so the pipe fills and back-pressures the source
  initial begin
    wait (phase == PH_SNK_STALL);
    @(posedge clk);
    hold_sink = 1'b1;
    repeat (200) @(posedge clk);
    hold_sink = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++)
      send(dir_tab[i].y, dir_tab[i].x, dir_tab[i].known, dir_tab[i].a);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % (N_RANDOM / 4) == 0 && i / (N_RANDOM / 4) < 4) begin
        phase = phase_e'(i / (N_RANDOM / 4));
        if (i == 2 * (N_RANDOM / 4)) drain();  // sender pause until empty
      end
      send(rand_coord(), rand_coord(), 1'b0, '0);
    end
    drain();
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0 && angle_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
